@@ rtl/rlsa_pkg.sv @@
// rlsa_pkg: shared widths, codes and types for the leaf rank/select/access block.
// No dependencies; imported by every module under rtl/.
package rlsa_pkg;

  // Default sizes, used as parameter defaults on the top level
  localparam int TEXT_DEPTH_DEF = 256;
  localparam int LEAF_MAX_DEF   = 64;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ACCESS = 2'd1,
    OP_RANK   = 2'd2,
    OP_SELECT = 2'd3
  } op_e;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_START  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_LENGTH = 1'b1;

  // Text memory command strobes
  typedef struct packed {
    logic we;
    logic re;
  } ram_cmd_t;

endpackage

@@ rtl/leaf_rank_select_access_top.sv @@
// leaf_rank_select_access_top: configuration registers and leaf window length;
// instantiates rlsa_ctrl and rlsa_text_ram. Depends on rlsa_pkg.
//
// Usage: fill the text store with load transactions (operation 0, position =
// store address, symbol = byte), write leaf_start (index 0) and leaf_length
// (index 1) on the configuration channel while the block is idle, then issue
// access (1), rank (2) or select (3) transactions. Every transaction returns
// exactly one result (result_value, status) on the output channel.
// One transaction is in work at a time; in_stall_o stays high until its result
// moves into the output register. Load writes a byte, access reads one; rank
// scans up to position, select up to the wanted occurrence or window end, and
// out-of-range or trivial not-found answers skip the scan. The scan reads the
// single text memory port one window byte per cycle, setting rank and select time.
// The output register lets the next transaction be accepted while a result
// waits; if the receiver stalls, the next finished result waits in the block
// and input stays stalled. Reset clears both registers and the handshake state;
// the text store is not cleared and must be loaded before it is read.
module leaf_rank_select_access_top
  import rlsa_pkg::*;
#(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
  parameter int LEAF_MAX   = LEAF_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  // Item channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [BYTE_W-1:0]    position_i,
  input  logic [BYTE_W-1:0]    symbol_i,
  input  logic [LEN_W-1:0]     occurrence_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    result_value_o,
  output logic [STAT_W-1:0]    status_o
);

  localparam int AW = $clog2(TEXT_DEPTH);

  logic [BYTE_W-1:0] leaf_start_q;
  logic [LEN_W-1:0]  leaf_length_q;
  logic [LEN_W-1:0]  leaf_len_eff;
  ram_cmd_t          ram_cmd;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  // Hold the leaf window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_start_q  <= '0;
      leaf_length_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LEAF_START:  leaf_start_q  <= cfg_data_i;
        CFG_LEAF_LENGTH: leaf_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the window length at the largest leaf
  assign leaf_len_eff = (32'(leaf_length_q) > LEAF_MAX) ? LEN_W'(LEAF_MAX) : leaf_length_q;

  rlsa_ctrl #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .symbol_i      (symbol_i),
    .occurrence_i  (occurrence_i),
    .leaf_start_i  (leaf_start_q),
    .leaf_len_i    (leaf_len_eff),
    .ram_cmd_o     (ram_cmd),
    .ram_addr_o    (ram_addr),
    .ram_wdata_o   (ram_wdata),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_value_o(result_value_o),
    .status_o      (status_o)
  );

  rlsa_text_ram #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_text_ram (
    .clk_i  (clk_i),
    .cmd_i  (ram_cmd),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

endmodule

@@ rtl/rlsa_text_ram.sv @@
// rlsa_text_ram: single-port text memory, one access per cycle, registered read data.
// Depends on rlsa_pkg (ram_cmd_t, BYTE_W).
module rlsa_text_ram
  import rlsa_pkg::*;
#(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
  localparam int AW = $clog2(TEXT_DEPTH)
) (
  input  logic              clk_i,
  input  ram_cmd_t          cmd_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [TEXT_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // Write on we; on re, read into the registered read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (cmd_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rlsa_ctrl.sv @@
// rlsa_ctrl: operation sequencer; scans the leaf window through the text memory
// one byte per cycle and holds the result register. Depends on rlsa_pkg.
module rlsa_ctrl
  import rlsa_pkg::*;
#(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
  localparam int AW = $clog2(TEXT_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Item channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [BYTE_W-1:0] position_i,
  input  logic [BYTE_W-1:0] symbol_i,
  input  logic [LEN_W-1:0]  occurrence_i,
  // Leaf window
  input  logic [BYTE_W-1:0] leaf_start_i,
  input  logic [LEN_W-1:0]  leaf_len_i,
  // Text memory
  output ram_cmd_t          ram_cmd_o,
  output logic [AW-1:0]     ram_addr_o,
  output logic [BYTE_W-1:0] ram_wdata_o,
  input  logic [BYTE_W-1:0] ram_rdata_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] result_value_o,
  output logic [STAT_W-1:0] status_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [BYTE_W-1:0] sym_q, sym_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  ki_q, ki_d;
  logic [LEN_W-1:0]  rk_q, rk_d;
  logic [LEN_W-1:0]  last_q, last_d;
  logic              iss_done_q, iss_done_d;
  logic              rdv_q, rdv_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [BYTE_W-1:0] res_val_q, res_val_d;
  logic [STAT_W-1:0] res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_val_q, out_val_d;
  logic [STAT_W-1:0] out_st_q, out_st_d;

  logic              match;
  logic [LEN_W-1:0]  cnt_inc;
  logic              in_range;
  ram_cmd_t          cmd;

  // Reduce a sum of two bytes modulo the store depth by restoring subtraction
  function automatic logic [AW-1:0] wrap_addr(input logic [BYTE_W:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int i = 4; i >= 0; i--) begin
      if (r >= (32'(TEXT_DEPTH) << i)) begin
        r = r - (32'(TEXT_DEPTH) << i);
      end
    end
    return AW'(r);
  endfunction

  assign match    = (ram_rdata_i == sym_q);
  assign cnt_inc  = cnt_q + LEN_W'(match);
  assign in_range = (position_i < {1'b0, leaf_len_i});

  // Next-state and datapath
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sym_d       = sym_q;
    left_d      = left_q;
    cnt_d       = cnt_q;
    ki_d        = ki_q;
    rk_d        = rk_q;
    last_d      = last_q;
    iss_done_d  = iss_done_q;
    rdv_d       = 1'b0;
    addr_d      = addr_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    cmd         = '0;

    // Drop the result once the receiver takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_e'(operation_i);
          sym_d      = symbol_i;
          left_d     = occurrence_i;
          cnt_d      = '0;
          ki_d       = '0;
          iss_done_d = 1'b0;
          res_val_d  = '0;
          res_st_d   = ST_OK;
          addr_d     = wrap_addr({1'b0, leaf_start_i});
          case (op_e'(operation_i))
            OP_LOAD: begin
              addr_d  = wrap_addr({1'b0, position_i});
              state_d = S_WRITE;
            end
            OP_ACCESS: begin
              if (!in_range) begin
                res_st_d = ST_RANGE;
                state_d  = S_RESULT;
              end else begin
                addr_d  = wrap_addr({1'b0, leaf_start_i} + {1'b0, position_i});
                last_d  = '0;
                state_d = S_SCAN;
              end
            end
            OP_RANK: begin
              if (!in_range) begin
                res_st_d = ST_RANGE;
                state_d  = S_RESULT;
              end else begin
                last_d  = position_i[LEN_W-1:0];
                state_d = S_SCAN;
              end
            end
            OP_SELECT: begin
              if (occurrence_i == '0 || leaf_len_i == '0) begin
                res_st_d = ST_NOT_FOUND;
                state_d  = S_RESULT;
              end else begin
                last_d  = leaf_len_i - LEN_W'(1);
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_RESULT;
            end
          endcase
        end
      end

      S_WRITE: begin
        cmd.we  = 1'b1;
        state_d = S_RESULT;
      end

      S_SCAN: begin
        // Issue the next window byte
        if (!iss_done_q) begin
          cmd.re     = 1'b1;
          addr_d     = (addr_q == AW'(TEXT_DEPTH - 1)) ? '0 : addr_q + AW'(1);
          ki_d       = ki_q + LEN_W'(1);
          iss_done_d = (ki_q == last_q);
          rdv_d      = 1'b1;
          rk_d       = ki_q;
        end
        // Evaluate the byte that returns from memory
        if (rdv_q) begin
          case (op_q)
            OP_ACCESS: begin
              res_val_d = ram_rdata_i;
              state_d   = S_RESULT;
            end
            OP_RANK: begin
              cnt_d = cnt_inc;
              if (rk_q == last_q) begin
                res_val_d = BYTE_W'(cnt_inc);
                state_d   = S_RESULT;
              end
            end
            OP_SELECT: begin
              if (match && left_q == LEN_W'(1)) begin
                res_val_d = BYTE_W'(rk_q);
                state_d   = S_RESULT;
              end else begin
                if (match) begin
                  left_d = left_q - LEN_W'(1);
                end
                if (rk_q == last_q) begin
                  res_st_d = ST_NOT_FOUND;
                  state_d  = S_RESULT;
                end
              end
            end
            default: begin
              state_d = S_RESULT;
            end
          endcase
          if (state_d == S_RESULT) begin
            rdv_d = 1'b0;
          end
        end
      end

      S_RESULT: begin
        // Hand over to the output register when it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_LOAD;
      sym_q       <= '0;
      left_q      <= '0;
      cnt_q       <= '0;
      ki_q        <= '0;
      rk_q        <= '0;
      last_q      <= '0;
      iss_done_q  <= 1'b0;
      rdv_q       <= 1'b0;
      addr_q      <= '0;
      res_val_q   <= '0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_st_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      sym_q       <= sym_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      ki_q        <= ki_d;
      rk_q        <= rk_d;
      last_q      <= last_d;
      iss_done_q  <= iss_done_d;
      rdv_q       <= rdv_d;
      addr_q      <= addr_d;
      res_val_q   <= res_val_d;
      res_st_q    <= res_st_d;
      out_valid_q <= out_valid_d;
      out_val_q   <= out_val_d;
      out_st_q    <= out_st_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign ram_cmd_o      = cmd;
  assign ram_addr_o     = addr_q;
  assign ram_wdata_o    = sym_q;
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign status_o       = out_st_q;

  // Memory never sees a read and a write in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd.we && cmd.re))
    else $error("rlsa_ctrl: read and write issued together");

  // A returning byte always belongs to the scanned range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && rdv_q) |-> (rk_q <= last_q))
    else $error("rlsa_ctrl: returned byte index past the scan end");

  // An accepted transaction leaves idle on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("rlsa_ctrl: accepted transaction not started");

  // Out-of-range and not-found results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_RANGE || status_o == ST_NOT_FOUND))
      |-> (result_value_o == '0))
    else $error("rlsa_ctrl: error status with nonzero value");

endmodule

@@ dv/testbench.sv @@
// testbench: self-checking bench for leaf_rank_select_access_top (load, access, rank, select).
// Depends on rlsa_pkg and the RTL under rtl/; directed table first, then random phases
// checked against a behavioral predictor of the leaf window.
module testbench;
  import rlsa_pkg::*;

  localparam int STORE_DEPTH = TEXT_DEPTH_DEF;
  localparam int LEAF_LIMIT  = LEAF_MAX_DEF;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 60;
  localparam int DRAIN_WAIT  = 80;

  typedef struct packed {
    op_e                op;
    logic [BYTE_W-1:0]  value;
    logic [STAT_W-1:0]  status;
  } answer_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    op_e                  op;
    logic [BYTE_W-1:0]    position;
    logic [BYTE_W-1:0]    symbol;
    logic [LEN_W-1:0]     occurrence;
    logic [BYTE_W-1:0]    value;
    logic [STAT_W-1:0]    status;
  } stim_row_t;

  // DUT ports
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = CFG_LEAF_START;
  logic [BYTE_W-1:0]    cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      operation_i    = OP_LOAD;
  logic [BYTE_W-1:0]    position_i     = '0;
  logic [BYTE_W-1:0]    symbol_i       = '0;
  logic [LEN_W-1:0]     occurrence_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [BYTE_W-1:0]    result_value_o;
  logic [STAT_W-1:0]    status_o;

  // Typed expectation travelling with the payload (directed rows only)
  logic                 drv_typed      = 1'b0;
  logic [BYTE_W-1:0]    drv_value      = '0;
  logic [STAT_W-1:0]    drv_status     = '0;

  // Shadow state of the block
  logic [BYTE_W-1:0]    store_model [STORE_DEPTH];
  logic [BYTE_W-1:0]    leaf_start_m   = '0;
  logic [LEN_W-1:0]     leaf_length_m  = '0;

  answer_t              answer_q [$];
  stim_row_t            stim_rows [$];
  int                   mismatch_cnt   = 0;
  int                   op_cnt [4]     = '{0, 0, 0, 0};
  int                   window_cnt     = 0;
  int                   burst_left     = 0;

  // Receiver stall pattern state
  int                   stall_mode     = 0;
  int                   mode_left      = 0;
  int                   hold_left      = 0;
  logic                 stall_level    = 1'b0;

  leaf_rank_select_access_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .symbol_i       (symbol_i),
    .occurrence_i   (occurrence_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Compute the answer for one transaction from the shadow store and window
  function automatic answer_t predict_answer(input op_e op, input logic [BYTE_W-1:0] pos,
                                             input logic [BYTE_W-1:0] sym,
                                             input logic [LEN_W-1:0] occ);
    answer_t          ans;
    int unsigned      n;
    int unsigned      cnt;
    int unsigned      left;
    logic [BYTE_W-1:0] addr;
    logic             found;
    ans.op     = op;
    ans.value  = '0;
    ans.status = ST_OK;
    n = (leaf_length_m > LEAF_LIMIT) ? LEAF_LIMIT : leaf_length_m;
    case (op)
      OP_ACCESS: begin
        if (pos >= n) begin
          ans.status = ST_RANGE;
        end else begin
          addr = leaf_start_m + pos;
          ans.value = store_model[addr];
        end
      end
      OP_RANK: begin
        if (pos >= n) begin
          ans.status = ST_RANGE;
        end else begin
          cnt = 0;
          for (int k = 0; k <= pos; k++) begin
            addr = leaf_start_m + k[BYTE_W-1:0];
            if (store_model[addr] == sym) cnt++;
          end
          ans.value = (cnt > 255) ? 8'hFF : cnt[BYTE_W-1:0];
        end
      end
      OP_SELECT: begin
        ans.status = ST_NOT_FOUND;
        left  = occ;
        found = 1'b0;
        if (left != 0) begin
          for (int k = 0; k < n; k++) begin
            addr = leaf_start_m + k[BYTE_W-1:0];
            if (!found && store_model[addr] == sym) begin
              left--;
              if (left == 0) begin
                found      = 1'b1;
                ans.value  = (k > 255) ? 8'hFF : k[BYTE_W-1:0];
                ans.status = ST_OK;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Predict at input acceptance, check at output acceptance
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = predict_answer(op_e'(operation_i), position_i, symbol_i, occurrence_i);
        if (drv_typed) begin
          want.value  = drv_value;
          want.status = drv_status;
        end
        if (operation_i == OP_LOAD) store_model[position_i] = symbol_i;
        answer_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("ERROR: result value %0d status %0d with no transaction pending",
                     result_value_o, status_o);
          mismatch_cnt++;
        end else begin
          want = answer_q.pop_front();
          op_cnt[int'(want.op)]++;
          if (result_value_o !== want.value || status_o !== want.status) begin
            if (mismatch_cnt < 10)
              $display("ERROR: op %s expected value %0d status %0d, got value %0d status %0d",
                       want.op.name(), want.value, want.status, result_value_o, status_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Receiver: switch between free flow, random stalls, long stretches and light stalls
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 400);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 1);
      2: begin
        if (hold_left == 0) begin
          hold_left   = $urandom_range(1, 40);
          stall_level = ~stall_level;
        end
        hold_left--;
        out_stall_i <= stall_level;
      end
      default: out_stall_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void add_item(input op_e op, input logic [BYTE_W-1:0] pos,
                                   input logic [BYTE_W-1:0] sym, input logic [LEN_W-1:0] occ,
                                   input logic [BYTE_W-1:0] v, input logic [STAT_W-1:0] s);
    stim_row_t row;
    row            = '0;
    row.op         = op;
    row.position   = pos;
    row.symbol     = sym;
    row.occurrence = occ;
    row.value      = v;
    row.status     = s;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
    stim_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.cfg_index = idx;
    row.cfg_data  = d;
    stim_rows.push_back(row);
  endfunction

  // Bias symbols toward a small alphabet so rank and select find matches
  function automatic logic [BYTE_W-1:0] pick_symbol();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h00;
      2, 3:    return 8'hFF;
      4, 5:    return 8'h5A;
      6:       return 8'hA5;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one transaction; bursts with random gaps, valid held until accepted
  task automatic send_item(input op_e op, input logic [BYTE_W-1:0] pos,
                           input logic [BYTE_W-1:0] sym, input logic [LEN_W-1:0] occ,
                           input logic typed, input logic [BYTE_W-1:0] v,
                           input logic [STAT_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    position_i   <= pos;
    symbol_i     <= sym;
    occurrence_i <= occ;
    drv_typed    <= typed;
    drv_value    <= v;
    drv_status   <= s;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Write one register once every pending result has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (answer_q.size() != 0);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_LEAF_START) begin
      leaf_start_m = d;
    end else begin
      leaf_length_m = d[LEN_W-1:0];
      window_cnt++;
    end
  endtask

  initial begin
    stim_row_t         row;
    int unsigned       n_eff;
    int unsigned       r;
    op_e               op;
    logic [BYTE_W-1:0] pos;
    logic [BYTE_W-1:0] sym;
    logic [LEN_W-1:0]  occ;
    logic [BYTE_W-1:0] start_d;
    logic [BYTE_W-1:0] length_d;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty window after reset, then a small window and a wrapped one
    add_item(OP_ACCESS, 8'd0,   8'h00, 7'd0, 8'd0, ST_RANGE);
    add_item(OP_RANK,   8'd255, 8'h00, 7'd0, 8'd0, ST_RANGE);
    add_item(OP_SELECT, 8'd0,   8'h00, 7'd1, 8'd0, ST_NOT_FOUND);
    add_item(OP_SELECT, 8'd0,   8'hFF, 7'd0, 8'd0, ST_NOT_FOUND);
    add_item(OP_LOAD,   8'd254, 8'hFF, 7'd0, 8'd0, ST_OK);
    add_item(OP_LOAD,   8'd255, 8'h00, 7'd0, 8'd0, ST_OK);
    add_item(OP_LOAD,   8'd0,   8'hFF, 7'd0, 8'd0, ST_OK);
    add_item(OP_LOAD,   8'd1,   8'h80, 7'd0, 8'd0, ST_OK);
    add_item(OP_LOAD,   8'd2,   8'hFF, 7'd0, 8'd0, ST_OK);
    add_item(OP_LOAD,   8'd3,   8'h01, 7'd0, 8'd0, ST_OK);
    add_item(OP_LOAD,   8'd4,   8'h00, 7'd0, 8'd0, ST_OK);
    add_item(OP_LOAD,   8'd5,   8'hFF, 7'd0, 8'd0, ST_OK);
    add_cfg(CFG_LEAF_START,  8'd0);
    add_cfg(CFG_LEAF_LENGTH, 8'd6);
    add_item(OP_ACCESS, 8'd0,   8'h00, 7'd0, 8'hFF, ST_OK);
    add_item(OP_ACCESS, 8'd5,   8'h00, 7'd0, 8'hFF, ST_OK);
    add_item(OP_ACCESS, 8'd6,   8'h00, 7'd0, 8'd0,  ST_RANGE);
    add_item(OP_RANK,   8'd5,   8'hFF, 7'd0, 8'd3,  ST_OK);
    add_item(OP_SELECT, 8'd0,   8'hFF, 7'd3, 8'd5,  ST_OK);
    add_item(OP_SELECT, 8'd0,   8'hFF, 7'd4, 8'd0,  ST_NOT_FOUND);
    add_item(OP_SELECT, 8'd0,   8'hFF, 7'd0, 8'd0,  ST_NOT_FOUND);
    add_cfg(CFG_LEAF_START,  8'd254);
    add_cfg(CFG_LEAF_LENGTH, 8'd4);
    add_item(OP_ACCESS, 8'd3,   8'h00, 7'd0, 8'h80, ST_OK);
    add_item(OP_RANK,   8'd3,   8'h00, 7'd0, 8'd1,  ST_OK);
    add_item(OP_SELECT, 8'd0,   8'hFF, 7'd2, 8'd2,  ST_OK);
    add_item(OP_ACCESS, 8'd255, 8'h00, 7'd0, 8'd0,  ST_RANGE);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_cfg)
        write_reg(row.cfg_index, row.cfg_data);
      else
        send_item(row.op, row.position, row.symbol, row.occurrence, 1'b1, row.value, row.status);
    end

    // Fill the whole store so any window reads written bytes only
    for (int a = 0; a < STORE_DEPTH; a++)
      send_item(OP_LOAD, a[BYTE_W-1:0], pick_symbol(), LEN_W'($urandom_range(0, 127)),
                1'b0, '0, '0);

    // Random phases: extreme windows first, then random ones
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin start_d = 8'd0;   length_d = 8'd64; end
        1: begin start_d = 8'd255; length_d = 8'hFF; end
        2: begin start_d = 8'h80;  length_d = 8'd0;  end
        3: begin start_d = 8'hC3;  length_d = 8'd1;  end
        default: begin
          start_d  = BYTE_W'($urandom_range(0, 255));
          length_d = ($urandom_range(0, 1) == 1) ? BYTE_W'($urandom_range(1, 64))
                                                 : BYTE_W'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_LEAF_START, start_d);
      write_reg(CFG_LEAF_LENGTH, length_d);
      n_eff = (leaf_length_m > LEAF_LIMIT) ? LEAF_LIMIT : leaf_length_m;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15)      op = OP_LOAD;
        else if (r < 35) op = OP_ACCESS;
        else if (r < 65) op = OP_RANK;
        else             op = OP_SELECT;
        sym = pick_symbol();
        if (op != OP_LOAD && n_eff > 0 && $urandom_range(0, 99) < 85)
          pos = BYTE_W'($urandom_range(0, n_eff - 1));
        else
          pos = BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0:       occ = '0;
          1:       occ = LEN_W'($urandom_range(0, 127));
          default: occ = LEN_W'($urandom_range(1, 12));
        endcase
        send_item(op, pos, sym, occ, 1'b0, '0, '0);
      end
    end

    // Drain, then watch for stray results
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (answer_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    mismatch_cnt += answer_q.size();

    $display("checked %0d load, %0d access, %0d rank, %0d select results over %0d windows",
             op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3], window_cnt);
    $display("mismatches: %0d", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rlsa_pkg.sv
rtl/rlsa_text_ram.sv
rtl/rlsa_ctrl.sv
rtl/leaf_rank_select_access_top.sv
dv/testbench.sv
